### hdl/tpfd_pkg.sv
// Shared types and constants of the trace port frame demultiplexer.
package tpfd_pkg;

  localparam int TIME_BITS   = 48;
  localparam int FRAME_SLOTS = 16;
  localparam int SLOT_BITS   = $clog2(FRAME_SLOTS);
  localparam int BANK_COUNT  = 2;
  localparam int COUNT_BITS  = 17;
  localparam int ID_BITS     = 7;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SELECT_STREAM = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SKIP_COUNT    = CFG_INDEX_BITS'(1);

  localparam logic [SLOT_BITS-1:0]  LAST_SLOT = SLOT_BITS'(FRAME_SLOTS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [7:0] SYNC_HEAD = 8'hFF;
  localparam logic [7:0] SYNC_TAIL = 8'h7F;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SEG_END = 1'b1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ID_BITS-1:0]   stream_id_t;

  typedef struct packed {
    logic [7:0] data;
    time_t      st;
    time_t      fin;
  } frame_entry_t;

  // Front to frame buffer: one slot write, done closes the frame
  typedef struct packed {
    logic                 we;
    logic                 done;
    logic [SLOT_BITS-1:0] slot;
    frame_entry_t         entry;
  } fb_wr_t;

  // Back to frame buffer: slot to read next cycle, release of the bank
  typedef struct packed {
    logic [SLOT_BITS-1:0] slot;
    logic                 release_bank;
  } fb_rd_req_t;

  // Frame buffer to back
  typedef struct packed {
    logic         avail;
    logic [7:0]   low;
    frame_entry_t entry;
  } fb_rd_stat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    time_t      span_start;
    time_t      span_end;
    logic       last;
  } out_item_t;

endpackage

### hdl/tpfd_in_if.sv
// Byte request channel of the trace port frame demultiplexer.
interface tpfd_in_if import tpfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  time_t      start_time;
  time_t      end_time;

  modport source (output valid, output data_byte, output start_time, output end_time,
                  input ready);
  modport sink (input valid, input data_byte, input start_time, input end_time,
                output ready);
endinterface

### hdl/tpfd_out_if.sv
// Result request channel of the trace port frame demultiplexer.
interface tpfd_out_if import tpfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] value;
  time_t      span_start;
  time_t      span_end;
  logic       last;

  modport source (output valid, output kind, output value, output span_start,
                  output span_end, output last, input ready);
  modport sink (input valid, input kind, input value, input span_start,
                input span_end, input last, output ready);
endinterface

### hdl/tpfd_cfg_if.sv
// Configuration write channel of the trace port frame demultiplexer.
interface tpfd_cfg_if import tpfd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/trace_port_frame_demux.sv
// Top level of the trace port frame demultiplexer.
//
// trace  : byte requests (data_byte, start_time, end_time), valid/ready.
// result : result requests (kind, value, span_start, span_end, last),
//          valid/ready; last marks the final result of a frame. Data
//          bytes of the selected stream come out with kind 0, ends of
//          segments of nonzero streams with kind 1.
// cfg    : register writes, always ready; index 0 select_stream (reset 1),
//          index 1 skip_count (reset 0). Write only while the block is idle.
// The front end takes one byte per cycle unless the frame buffer stalls it,
// and files it into a frame slot from its input register. A frame of 16
// bytes goes to a two-bank frame buffer; the back end unpacks it at one
// slot per cycle while results are taken, with an extra step for every
// delayed stream change, a start and a flush, set by the back end's slot
// sequencer. A result leaves once the next one is found, the last at flush.
// trace stalls only while both banks hold frames not yet unpacked. When the
// result receiver stalls, the back end holds in its output register and
// one lookahead result, then stops. Reset clears the counters, sync count,
// stream state and both bank flags; the block takes bytes right after reset.
module trace_port_frame_demux import tpfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tpfd_in_if.sink     trace,
  tpfd_out_if.source  result,
  tpfd_cfg_if.sink    cfg
);

  stream_id_t  select_stream;
  logic [15:0] skip_count;

  fb_wr_t      wr;
  logic        wr_ok;
  fb_rd_req_t  rd_req;
  fb_rd_stat_t rd_stat;

  // Configuration registers; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      select_stream <= ID_BITS'(1);
      skip_count    <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_SELECT_STREAM) begin
        select_stream <= cfg.data[ID_BITS-1:0];
      end else if (cfg.index == REG_SKIP_COUNT) begin
        skip_count <= cfg.data[15:0];
      end
    end
  end

  // Front: gap check, offset skip, sync detection, slot fill
  tpfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .skip_count (skip_count),
    .trace      (trace),
    .wr_ok      (wr_ok),
    .wr         (wr)
  );

  // Queue: two frame banks, one filling while the other unpacks
  tpfd_fbuf u_fbuf (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .wr_ok (wr_ok),
    .req   (rd_req),
    .stat  (rd_stat)
  );

  // Back: slot sequencer, stream tracking, output register
  tpfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .select_stream (select_stream),
    .stat          (rd_stat),
    .req           (rd_req),
    .result        (result)
  );

endmodule

### hdl/tpfd_front.sv
// Front end: takes bytes, tracks gaps, offset and sync, fills frame slots.
module tpfd_front import tpfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       skip_count,
  tpfd_in_if.sink           trace,
  input  logic              wr_ok,
  output fb_wr_t            wr
);

  localparam logic [2:0] SYNC_LEN = 3'd4;

  logic                  a_valid;
  logic [7:0]            a_byte;
  time_t                 a_st;
  time_t                 a_fin;
  time_t                 a_gap;
  time_t                 a_len;
  time_t                 prev_end;
  logic [SLOT_BITS-1:0]  fill;
  logic [COUNT_BITS-1:0] byte_count;
  logic [2:0]            sync_cnt;
  logic [7:0]            win [3];

  logic                  accept;
  logic                  b_go;
  logic                  restart;
  logic [SLOT_BITS-1:0]  fill_eff;
  logic [COUNT_BITS-1:0] count_next;
  logic                  discard;
  logic [2:0]            sync_cnt_next;
  logic                  sync_hit;

  assign trace.ready = !a_valid || wr_ok;
  assign accept      = trace.valid && trace.ready;
  assign b_go        = a_valid && wr_ok;

  always_comb begin
    restart       = a_gap > a_len;
    fill_eff      = restart ? '0 : fill;
    count_next    = (byte_count == COUNT_MAX) ? byte_count : byte_count + 1'b1;
    discard       = count_next < {1'b0, skip_count};
    sync_cnt_next = (sync_cnt == SYNC_LEN) ? sync_cnt : sync_cnt + 1'b1;
    sync_hit      = !discard && (sync_cnt_next == SYNC_LEN) &&
                    (win[0] == SYNC_HEAD) && (win[1] == SYNC_HEAD) &&
                    (win[2] == SYNC_HEAD) && (a_byte == SYNC_TAIL);
    wr.we         = b_go;
    wr.slot       = fill_eff;
    wr.entry      = '{data: a_byte, st: a_st, fin: a_fin};
    wr.done       = b_go && !discard && !sync_hit && (fill_eff == LAST_SLOT);
  end

  // Gap and duration are both taken at acceptance, compared from these registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_byte <= trace.data_byte;
      a_st   <= trace.start_time;
      a_fin  <= trace.end_time;
      a_gap  <= trace.start_time - prev_end;
      a_len  <= trace.end_time - trace.start_time;
    end
    if (b_go && !discard) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= a_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      prev_end   <= '0;
      fill       <= '0;
      byte_count <= '0;
      sync_cnt   <= '0;
    end else begin
      if (accept) begin
        a_valid  <= 1'b1;
        prev_end <= trace.end_time;
      end else if (b_go) begin
        a_valid <= 1'b0;
      end
      if (b_go) begin
        byte_count <= count_next;
        if (discard) begin
          fill <= '0;
        end else if (sync_hit) begin
          fill     <= '0;
          sync_cnt <= '0;
        end else begin
          sync_cnt <= sync_cnt_next;
          fill     <= (fill_eff == LAST_SLOT) ? '0 : fill_eff + 1'b1;
        end
      end
    end
  end

endmodule

### hdl/tpfd_fbuf.sv
// Two-bank frame buffer between front and back end.
module tpfd_fbuf import tpfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  fb_wr_t      wr,
  output logic        wr_ok,
  input  fb_rd_req_t  req,
  output fb_rd_stat_t stat
);

  localparam int DEPTH = BANK_COUNT * FRAME_SLOTS;

  frame_entry_t    mem [DEPTH];
  frame_entry_t    rd_q;
  logic [7:0]      low_byte [BANK_COUNT];
  logic [BANK_COUNT-1:0] full;
  logic [BANK_COUNT-1:0] full_next;
  logic            wbank;
  logic            rbank;

  assign wr_ok      = !full[wbank];
  assign stat.avail = full[rbank];
  assign stat.low   = low_byte[rbank];
  assign stat.entry = rd_q;

  // Mark the bank just closed, free the bank just unpacked
  always_comb begin
    full_next = full;
    if (wr.we && wr.done) begin
      full_next[wbank] = 1'b1;
    end
    if (req.release_bank) begin
      full_next[rbank] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[{wbank, wr.slot}] <= wr.entry;
    end
    rd_q <= mem[{rbank, req.slot}];
    if (wr.we && wr.slot == LAST_SLOT) begin
      low_byte[wbank] <= wr.entry.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= '0;
      wbank <= 1'b0;
      rbank <= 1'b0;
    end else begin
      full <= full_next;
      if (wr.we && wr.done) begin
        wbank <= !wbank;
      end
      if (req.release_bank) begin
        rbank <= !rbank;
      end
    end
  end

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr.we |-> !full[wbank])
    else $error("write into a bank that awaits unpacking");

  a_bank_order: assert property (@(posedge clk) disable iff (rst)
    ($countones(full) == 1) |-> (wbank != rbank))
    else $error("bank pointers disagree with full flags");

endmodule

### hdl/tpfd_back.sv
// Back end: a slot per cycle unless stalled; tracks streams, emits results.
module tpfd_back import tpfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  stream_id_t  select_stream,
  input  fb_rd_stat_t stat,
  output fb_rd_req_t  req,
  tpfd_out_if.source  result
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]           state;
  logic [SLOT_BITS-1:0] slot;
  logic                 phase;
  logic                 delay_pend;
  stream_id_t           delay_id;
  stream_id_t           cur_stream;
  time_t                seg_start;
  logic                 pend_valid;
  out_item_t            pend;
  logic                 o_valid;
  out_item_t            o_item;

  logic                 out_free;
  logic [7:0]           b;
  logic                 lb;
  logic                 is_data;
  logic [7:0]           data_val;
  logic                 chg;
  logic                 chg_delayed;
  stream_id_t           chg_id;
  time_t                chg_at;
  logic                 chg_diff;
  logic                 set_delay;
  logic                 enter_phase;
  logic                 advance;
  logic                 emit;
  out_item_t            new_item;
  logic                 step;
  logic                 flush_go;
  logic                 o_load;
  out_item_t            o_next;

  assign out_free = !o_valid || result.ready;

  // Decode the current slot
  always_comb begin
    b           = stat.entry.data;
    lb          = stat.low[slot[SLOT_BITS-1:1]];
    is_data     = 1'b0;
    data_val    = b;
    chg         = 1'b0;
    chg_delayed = 1'b0;
    chg_id      = delay_id;
    chg_at      = stat.entry.fin;
    set_delay   = 1'b0;
    enter_phase = 1'b0;
    advance     = 1'b0;
    priority if (phase || (slot == LAST_SLOT && delay_pend)) begin
      // delayed ID change closes at the end of the odd slot
      chg         = 1'b1;
      chg_delayed = 1'b1;
      advance     = 1'b1;
    end else if (!slot[0]) begin
      if (b[0]) begin
        if (lb) begin
          set_delay = 1'b1;
        end else begin
          chg    = 1'b1;
          chg_id = b[7:1];
          chg_at = stat.entry.st;
        end
      end else begin
        is_data  = 1'b1;
        data_val = {b[7:1], lb};
      end
      advance = 1'b1;
    end else begin
      if (slot != LAST_SLOT) begin
        is_data = 1'b1;
      end
      if (delay_pend && slot != LAST_SLOT) begin
        enter_phase = 1'b1;
      end else begin
        advance = 1'b1;
      end
    end

    chg_diff = chg && (cur_stream != chg_id);
    new_item = '0;
    emit     = 1'b0;
    if (is_data) begin
      emit     = (cur_stream == select_stream);
      new_item = '{kind: KIND_DATA, value: data_val, span_start: stat.entry.st,
                   span_end: stat.entry.fin, last: 1'b0};
    end else if (chg_diff && cur_stream != '0) begin
      emit     = 1'b1;
      new_item = '{kind: KIND_SEG_END, value: {1'b0, cur_stream},
                   span_start: seg_start, span_end: chg_at, last: 1'b0};
    end

    step     = (state == S_EXEC) && (!emit || !pend_valid || out_free);
    flush_go = (state == S_FLUSH) && (!pend_valid || out_free);

    // The held result goes out once the next one exists, or as last at flush
    o_load = (step && emit && pend_valid) || (flush_go && pend_valid);
    o_next = pend;
    o_next.last = flush_go;

    req.release_bank = flush_go;
    unique case (state)
      S_IDLE:  req.slot = '0;
      S_EXEC:  req.slot = (step && advance && slot != LAST_SLOT) ? slot + 1'b1 : slot;
      default: req.slot = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      pend <= new_item;
    end
    if (o_load) begin
      o_item <= o_next;
    end
    if (step && set_delay) begin
      delay_id <= b[7:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot       <= '0;
      phase      <= 1'b0;
      delay_pend <= 1'b0;
      cur_stream <= '0;
      seg_start  <= '0;
      pend_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (stat.avail) begin
            state      <= S_EXEC;
            slot       <= '0;
            phase      <= 1'b0;
            delay_pend <= 1'b0;
          end
        end
        S_EXEC: begin
          if (step) begin
            if (emit) begin
              pend_valid <= 1'b1;
            end
            if (chg_diff) begin
              cur_stream <= chg_id;
              seg_start  <= chg_at;
            end
            if (set_delay) begin
              delay_pend <= 1'b1;
            end
            if (chg_delayed) begin
              delay_pend <= 1'b0;
              phase      <= 1'b0;
            end
            if (enter_phase) begin
              phase <= 1'b1;
            end
            if (advance) begin
              if (slot == LAST_SLOT) begin
                state <= S_FLUSH;
              end else begin
                slot <= slot + 1'b1;
              end
            end
          end
        end
        S_FLUSH: begin
          if (flush_go) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid      = o_valid;
  assign result.kind       = o_item.kind;
  assign result.value      = o_item.value;
  assign result.span_start = o_item.span_start;
  assign result.span_end   = o_item.span_end;
  assign result.last       = o_item.last;

  a_bank_held: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> stat.avail)
    else $error("frame bank released while still unpacking");

  a_phase_slot: assert property (@(posedge clk) disable iff (rst)
    phase |-> (state == S_EXEC && slot[0] && slot != LAST_SLOT))
    else $error("delayed change phase outside an odd data slot");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!pend_valid && !delay_pend))
    else $error("result or delayed change left over after a frame");

endmodule
